// ===== rtl/core/alfr_pkg.sv =====
// Shared types, constants and helper functions for the additive lagged-Fibonacci generator.
package alfr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 63;

  localparam logic [30:0] LCG_MUL   = 31'd1103515245;
  localparam logic [30:0] LCG_INC   = 31'd12345;
  localparam logic [31:0] PM_Q      = 32'd127773;
  // 2^48 / 127773 rounded down a little; quotient estimate is exact or one low
  localparam logic [31:0] PM_RECIP  = 32'd2202930000;
  localparam logic [16:0] PM_A      = 17'd16807;
  localparam logic [11:0] PM_R      = 12'd2836;
  localparam logic [33:0] PM_M      = 34'h07fffffff;
  localparam int unsigned WARM_MULT = 10;

  localparam logic [2:0] TYPE_LCG = 3'd0;
  localparam logic [2:0] TYPE_MAX = 3'd4;
  localparam logic [2:0] TYPE_RST = 3'd3;
  localparam logic [31:0] SEED_RST = 32'd1;

  typedef enum logic {
    REG_TYPE = 1'b0,
    REG_SEED = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEED0,
    OP_DIV_SEED,
    OP_SEED_MUL,
    OP_SEED_WR,
    OP_WARM_INIT,
    OP_RD,
    OP_LCG_MUL,
    OP_WR,
    OP_DIV_MOD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic bound_zero;
    logic seeded;
    logic type_zero;
    logic seed_last;
    logic warm_zero;
    logic div_busy;
    logic out_busy;
  } sts_t;

  function automatic logic [6:0] deg_of(input logic [2:0] t);
    logic [6:0] d;
    case (t)
      3'd1:    d = 7'd7;
      3'd2:    d = 7'd15;
      3'd3:    d = 7'd31;
      3'd4:    d = 7'd63;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

  function automatic logic [6:0] sep_of(input logic [2:0] t);
    logic [6:0] s;
    case (t)
      3'd1:    s = 7'd3;
      3'd2:    s = 7'd1;
      3'd3:    s = 7'd3;
      3'd4:    s = 7'd1;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] eff_type(input logic [2:0] t, input logic [6:0] depth);
    logic [2:0] e;
    e = (t > TYPE_MAX) ? TYPE_MAX : t;
    for (int k = 0; k < 3; k++) begin
      if (e > 3'd1 && deg_of(e) > depth) begin
        e = e - 3'd1;
      end
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/alfr_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module alfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/alfr_ctrl.sv =====
// Sequencing state machine: seeding, warm-up, draw and modulo phases.
module alfr_ctrl import alfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEED0, S_SDIV, S_SWAIT, S_SMUL, S_SWR, S_WINIT,
    S_RD, S_LMUL, S_WR, S_MDIV, S_MWAIT, S_FIN
  } state_e;

  state_e state_q;
  logic   out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !sts_i.out_busy || out_ready_i;

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      S_SEED0: cmd_o.op = OP_SEED0;
      S_SDIV:  cmd_o.op = OP_DIV_SEED;
      S_SMUL:  cmd_o.op = OP_SEED_MUL;
      S_SWR:   cmd_o.op = OP_SEED_WR;
      S_WINIT: cmd_o.op = OP_WARM_INIT;
      S_RD:    cmd_o.op = OP_RD;
      S_LMUL:  cmd_o.op = OP_LCG_MUL;
      S_WR:    cmd_o.op = OP_WR;
      S_MDIV:  cmd_o.op = OP_DIV_MOD;
      S_FIN:   if (out_free) cmd_o.op = OP_OUT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: begin
          if (sts_i.bound_zero) state_q <= S_FIN;
          else if (!sts_i.seeded) state_q <= S_SEED0;
          else state_q <= S_RD;
        end
        S_SEED0: state_q <= sts_i.type_zero ? S_RD : S_SDIV;
        S_SDIV:  state_q <= S_SWAIT;
        S_SWAIT: if (!sts_i.div_busy) state_q <= S_SMUL;
        S_SMUL:  state_q <= S_SWR;
        S_SWR:   state_q <= sts_i.seed_last ? S_WINIT : S_SDIV;
        S_WINIT: state_q <= S_RD;
        S_RD:    state_q <= sts_i.type_zero ? S_LMUL : S_WR;
        S_LMUL:  state_q <= S_WR;
        S_WR:    state_q <= sts_i.warm_zero ? S_MDIV : S_RD;
        S_MDIV:  state_q <= S_MWAIT;
        S_MWAIT: if (!sts_i.div_busy) state_q <= S_FIN;
        S_FIN:   if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/alfr_dp.sv =====
// Datapath: config registers, table RAM, indices, seeding math, shared divider, output register.
module alfr_dp import alfr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [31:0] bound_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] value_in_range_o,
  output logic [30:0] raw_draw_o,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned WW = $clog2(WARM_MULT * TABLE_DEPTH + 1);
  localparam logic [6:0] DEPTH7 = 7'(TABLE_DEPTH);

  logic [2:0]    type_q;
  logic [31:0]   seed_q;
  logic          seeded_q;
  logic [31:0]   bound_q;
  logic [AW-1:0] f_q, r_q, i_q;
  logic [WW-1:0] cnt_q;
  logic [31:0]   prev_q;
  logic [31:0]   p1_q;
  logic [25:0]   p2_q;
  logic [30:0]   prod_q;
  logic [30:0]   raw_q;
  logic [31:0]   rem_q, quo_q, dvs_q;
  logic [5:0]    dcnt_q;
  logic          dbusy_q;
  logic          smode_q;
  logic          out_valid_q;
  logic [31:0]   out_val_q;
  logic [30:0]   out_raw_q;

  logic [2:0]    t;
  logic [6:0]    deg, sep;
  logic [AW-1:0] feff, reff, fnx, rnx;
  logic [6:0]    f7, r7;
  logic          we;
  logic [AW-1:0] waddr, ra_a, ra_b;
  logic [31:0]   wdata, rd_a, rd_b, sum, absx;
  logic [33:0]   sdiff, sv;
  logic [30:0]   lv;
  logic [32:0]   rs, dtry;
  logic [63:0]   rmul;

  assign t   = eff_type(type_q, DEPTH7);
  assign deg = deg_of(t);
  assign sep = sep_of(t);

  assign f7   = {{(7-AW){1'b0}}, f_q};
  assign r7   = {{(7-AW){1'b0}}, r_q};
  assign feff = (f7 >= deg) ? '0 : f_q;
  assign reff = (r7 >= deg) ? '0 : r_q;
  assign fnx  = ({{(7-AW){1'b0}}, feff} + 7'd1 >= deg) ? '0 : feff + AW'(1);
  assign rnx  = ({{(7-AW){1'b0}}, reff} + 7'd1 >= deg) ? '0 : reff + AW'(1);

  assign sum  = rd_a + rd_b;
  assign lv   = prod_q + LCG_INC;
  assign absx = prev_q[31] ? (~prev_q + 32'd1) : prev_q;
  assign rmul = {32'b0, absx} * {32'b0, PM_RECIP};

  always_comb begin
    sdiff = {2'b0, p1_q} - {8'b0, p2_q};
    sv    = prev_q[31] ? (~sdiff + 34'd1) : sdiff;
    if (sv[33] || sv == '0) begin
      sv = sv + PM_M;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd_a;
    case (cmd_i.op)
      OP_SEED0: begin
        we    = 1'b1;
        wdata = seed_q;
      end
      OP_SEED_WR: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = sv[31:0];
      end
      OP_WR: begin
        we = 1'b1;
        if (t == TYPE_LCG) begin
          wdata = {1'b0, lv};
        end else begin
          waddr = feff;
          wdata = sum;
        end
      end
      default: we = 1'b0;
    endcase
  end

  assign ra_a = (t == TYPE_LCG) ? '0 : feff;
  assign ra_b = reff;

  alfr_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ra_a),
    .raddr_b_i (ra_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign rs   = {rem_q, quo_q[31]};
  assign dtry = rs - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q      <= TYPE_RST;
      seed_q      <= SEED_RST;
      seeded_q    <= 1'b0;
      f_q         <= '0;
      r_q         <= '0;
      i_q         <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      dbusy_q     <= 1'b0;
      smode_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seeded_q <= 1'b0;
        unique case (cfg_idx_i)
          REG_TYPE: type_q <= cfg_data_i[2:0];
          REG_SEED: seed_q <= cfg_data_i;
          default:  seeded_q <= 1'b0;
        endcase
      end
      if (dbusy_q) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
      end
      if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_SEED0: begin
          seeded_q <= 1'b1;
          i_q      <= AW'(1);
        end
        OP_DIV_SEED: begin
          dbusy_q <= 1'b1;
          dcnt_q  <= 6'd2;
          smode_q <= 1'b1;
        end
        OP_DIV_MOD: begin
          dbusy_q <= 1'b1;
          dcnt_q  <= 6'd32;
          smode_q <= 1'b0;
        end
        OP_SEED_WR: i_q <= i_q + AW'(1);
        OP_WARM_INIT: begin
          f_q   <= sep[AW-1:0];
          r_q   <= '0;
          cnt_q <= WW'(deg) * WW'(WARM_MULT);
        end
        OP_WR: begin
          if (t != TYPE_LCG) begin
            f_q <= fnx;
            r_q <= rnx;
          end
          if (cnt_q != '0) cnt_q <= cnt_q - WW'(1);
        end
        OP_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (dbusy_q) begin
      if (smode_q) begin
        // quotient estimate is exact or one low: form remainder, then fix up once
        if (dcnt_q == 6'd2) begin
          rem_q <= absx - (32'(quo_q[15:0]) * PM_Q);
        end else if (rem_q >= PM_Q) begin
          rem_q <= rem_q - PM_Q;
          quo_q <= quo_q + 32'd1;
        end
      end else begin
        rem_q <= dtry[32] ? rs[31:0] : dtry[31:0];
        quo_q <= {quo_q[30:0], ~dtry[32]};
      end
    end
    case (cmd_i.op)
      OP_LOAD:  bound_q <= bound_i;
      OP_SEED0: prev_q  <= seed_q;
      OP_DIV_SEED: quo_q <= {16'b0, rmul[63:48]};
      OP_SEED_MUL: begin
        p1_q <= 32'(PM_A) * 32'(rem_q[16:0]);
        p2_q <= 26'(PM_R) * 26'(quo_q[14:0]);
      end
      OP_SEED_WR: prev_q <= sv[31:0];
      OP_LCG_MUL: prod_q <= 31'(rd_a[30:0] * LCG_MUL);
      OP_WR:      raw_q  <= (t == TYPE_LCG) ? lv : sum[31:1];
      OP_DIV_MOD: begin
        rem_q <= '0;
        quo_q <= {1'b0, raw_q};
        dvs_q <= bound_q;
      end
      OP_OUT: begin
        out_val_q <= (bound_q == '0) ? '0 : rem_q;
        out_raw_q <= (bound_q == '0) ? '0 : raw_q;
      end
      default: ;
    endcase
  end

  assign sts_o.bound_zero = (bound_q == '0);
  assign sts_o.seeded     = seeded_q;
  assign sts_o.type_zero  = (t == TYPE_LCG);
  assign sts_o.seed_last  = ({{(7-AW){1'b0}}, i_q} + 7'd1 == deg);
  assign sts_o.warm_zero  = (cnt_q == '0);
  assign sts_o.div_busy   = dbusy_q;
  assign sts_o.out_busy   = out_valid_q;

  assign out_valid_o      = out_valid_q;
  assign value_in_range_o = out_val_q;
  assign raw_draw_o       = out_raw_q;

endmodule

// ===== rtl/core/additive_lagged_fibonacci_rng_top.sv =====
// A bound of zero skips the draw and returns zero; a draw on a seeded table (trinomial or LCG) ends
// in the 32-step bit-serial divider that forms the remainder.
// After reset or a register write the next draw with a nonzero bound first reseeds: for the trinomial
// types one reciprocal-multiply Park-Miller step per table entry after the first, then 10 * degree warm-up draws.
// Throughput: one item at a time; the next item is taken while the result waits in the output.
// Reset: type 3, seed 1, unseeded; table contents undefined until seeded.
module additive_lagged_fibonacci_rng_top import alfr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_in_range_o,
  output logic [30:0] raw_draw_o
);

  cmd_t cmd;
  sts_t sts;

  alfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  alfr_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .bound_i          (bound_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .value_in_range_o (value_in_range_o),
    .raw_draw_o       (raw_draw_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

// ===== tb/additive_lagged_fibonacci_rng_top_tb.sv =====
// Testbench for the additive lagged-Fibonacci generator: random bounded draws checked against a predictor.
module additive_lagged_fibonacci_rng_top_tb;
  import alfr_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [30:0] raw;
  } draw_t;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DEG[5] = '{0, 7, 15, 31, 63};
  localparam int unsigned SEP[5] = '{0, 3, 1, 3, 1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] bound_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_in_range_o;
  logic [30:0] raw_draw_o;

  additive_lagged_fibonacci_rng_top dut (.*);

  always #1 clk_i = ~clk_i;

  // generator model state
  logic [31:0] fib_table[63];
  int unsigned front_pos, rear_pos;
  logic        table_seeded;
  logic [2:0]  gen_type;
  logic [31:0] seed_reg;

  logic [31:0] bound_q[$];
  draw_t       draw_q[$];
  int unsigned errors, drawn, in_gap, out_gap, hold_cnt, cycles;
  logic        held, calm;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [30:0] advance_gen(input int unsigned t);
    int unsigned f, r, d;
    logic [31:0] v;
    if (t == 0) begin
      v = (fib_table[0] * 32'd1103515245 + 32'd12345) & 32'h7fffffff;
      fib_table[0] = v;
      return v[30:0];
    end
    d = DEG[t];
    f = (front_pos >= d) ? 0 : front_pos;
    r = (rear_pos >= d) ? 0 : rear_pos;
    fib_table[f] = fib_table[f] + fib_table[r];
    v = fib_table[f];
    f++;
    if (f >= d) f = 0;
    r++;
    if (r >= d) r = 0;
    front_pos = f;
    rear_pos = r;
    return v[31:1];
  endfunction

  function automatic void seed_gen(input int unsigned t);
    longint x, hi, lo, v;
    logic [30:0] dummy;
    fib_table[0] = seed_reg;
    if (t == 0) return;
    for (int unsigned i = 1; i < DEG[t]; i++) begin
      x = longint'($signed(fib_table[i-1]));
      hi = x / 127773;
      lo = x % 127773;
      v = 16807 * lo - 2836 * hi;
      if (v <= 0) v += 64'h7fffffff;
      fib_table[i] = v[31:0];
    end
    front_pos = SEP[t];
    rear_pos = 0;
    for (int unsigned i = 0; i < 10 * DEG[t]; i++) dummy = advance_gen(t);
  endfunction

  function automatic void predict_draw(input logic [31:0] bound);
    int unsigned t;
    draw_t d;
    if (bound == 0) begin
      d = '0;
    end else begin
      t = (gen_type > TYPE_MAX) ? TYPE_MAX : gen_type;
      if (!table_seeded) begin
        seed_gen(t);
        table_seeded = 1'b1;
      end
      d.raw = advance_gen(t);
      d.value = {1'b0, d.raw} % bound;
    end
    draw_q.push_back(d);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_draw(bound_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0 || bound_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          bound_i <= bound_q.pop_front();
          in_gap = pick_gap();
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
      hold_cnt = 0;
      held = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        drawn++;
        if (draw_q.size() == 0) begin
          report_mismatch("unexpected item", value_in_range_o, 32'h0);
        end else begin
          want = draw_q.pop_front();
          if (value_in_range_o !== want.value)
            report_mismatch("value_in_range", value_in_range_o, want.value);
          if (raw_draw_o !== want.raw)
            report_mismatch("raw_draw", {1'b0, raw_draw_o}, {1'b0, want.raw});
        end
      end
      if (!held && drawn >= 300) begin
        held = 1'b1;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_TYPE) gen_type = data[2:0];
    else seed_reg = data;
    table_seeded = 1'b0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (bound_q.size() == 0 && !in_valid_i && draw_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_bound();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0;
    if (r < 40) return $urandom_range(1, 100);
    if (r < 55) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  initial begin
    logic [2:0]  types[8];
    logic [31:0] seeds[8];
    errors = 0;
    drawn = 0;
    cycles = 0;
    calm = 1'b0;
    for (int i = 0; i < 63; i++) fib_table[i] = '0;
    front_pos = 0;
    rear_pos = 0;
    table_seeded = 1'b0;
    gen_type = TYPE_RST;
    seed_reg = SEED_RST;
    types = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd5, 3'd6, 3'd3};
    seeds = '{32'h0, 32'hffffffff, 32'h80000000, 32'd12345, 32'h7fffffff,
              $urandom, $urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero bound first, then extremes
    foreach (types[k]) begin end
    bound_q = '{32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 32'hffffffff, 32'hfffffffe,
                32'h80000000, 32'h7fffffff, 32'h80000001, 32'h40000000, 32'h0,
                32'h55555555, 32'haaaaaaaa, 32'd10, 32'd1000};
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        write_reg(REG_TYPE, {29'h0, types[p]});
      end else begin
        write_reg(REG_TYPE, {$urandom_range(0, 1) ? 29'h0 : 29'h1fffffff, types[p]});
        write_reg(REG_SEED, seeds[p]);
      end
      calm = (p == 5);
      bound_q.push_back(32'hffffffff);
      bound_q.push_back(32'h0);
      for (int i = 0; i < 180; i++) bound_q.push_back(rand_bound());
      wait_idle();
    end
    // seed change alone, same type
    write_reg(REG_SEED, $urandom);
    for (int i = 0; i < 40; i++) bound_q.push_back(rand_bound());
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/alfr_pkg.sv
rtl/core/alfr_ram.sv
rtl/core/alfr_ctrl.sv
rtl/core/alfr_dp.sv
rtl/core/additive_lagged_fibonacci_rng_top.sv
tb/additive_lagged_fibonacci_rng_top_tb.sv
